// ===== hw/rtl/alm_pkg.sv =====
// Package: shared types and constants for the audio level meter.
`timescale 1ns / 1ps
package alm_pkg;
  localparam int MaxBlockDefault = 1024;
  localparam int SumW  = 48;
  localparam int LvlW  = 16;
  localparam int TimeW = 32;
  localparam int FacW  = 17;
  localparam int BarsW = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegEnable    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSmoothing = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHoldTime  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClipThr   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxBars   = 3'd4;

  // Closed block handed from the accumulator to the level stage.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [16:0]      count;
    logic [TimeW-1:0] stamp;
  } blk_t;

  typedef struct packed {
    logic [LvlW-1:0]  rms_level;
    logic [LvlW-1:0]  smoothed_level;
    logic [LvlW-1:0]  peak_level;
    logic             clipping;
    logic [BarsW-1:0] level_bars;
    logic [BarsW-1:0] level_percent;
  } res_t;

  typedef struct packed {
    logic [FacW-1:0]  smoothing_factor;
    logic [TimeW-1:0] hold_time_ms;
    logic [LvlW-1:0]  clip_threshold;
    logic [BarsW-1:0] bar_count;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SQRT, S_SMOOTH, S_SCALE, S_OUT
  } bst_t;
endpackage

// ===== hw/rtl/alm_if.sv =====
// Interfaces: valid/ready channels for samples and results.
`timescale 1ns / 1ps
interface alm_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample;
  logic        block_end;
  logic [31:0] time_ms;
  modport source (output valid, sample, block_end, time_ms, input ready);
  modport sink   (input valid, sample, block_end, time_ms, output ready);
endinterface

interface alm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rms_level;
  logic [15:0] smoothed_level;
  logic [15:0] peak_level;
  logic        clipping;
  logic [6:0]  level_bars;
  logic [6:0]  level_percent;
  modport source (output valid, rms_level, smoothed_level, peak_level, clipping,
                  level_bars, level_percent, input ready);
  modport sink   (input valid, rms_level, smoothed_level, peak_level, clipping,
                  level_bars, level_percent, output ready);
endinterface

// ===== hw/rtl/alm_front.sv =====
// Front: per-sample square accumulate and block closing.
`timescale 1ns / 1ps
module alm_front #(
  parameter int MAX_BLOCK = alm_pkg::MaxBlockDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                enable,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  sample,
  input  logic                block_end,
  input  logic [31:0]         time_ms,
  output logic                blk_valid,
  input  logic                blk_ready,
  output alm_pkg::blk_t       blk
);
  import alm_pkg::*;
  localparam int CntW = $clog2(MAX_BLOCK + 1);

  logic [SumW-1:0] square_sum;
  logic [CntW-1:0] sample_count;
  logic [15:0]     mag;
  logic [31:0]     sq;
  logic [SumW-1:0] sum_next;
  logic [CntW-1:0] cnt_next;
  logic            close, take;

  assign mag      = sample[15] ? 16'(-sample) : 16'(sample);
  assign sq       = mag * mag;
  assign sum_next = square_sum + SumW'(sq);
  assign cnt_next = sample_count + CntW'(1);
  assign close    = block_end || (cnt_next == CntW'(MAX_BLOCK));
  // Take and drop words while disabled; hold off only a closing word that
  // would find the queue slot full, and every word during the clear cycle.
  assign in_ready = !clear && (!enable || !(blk_valid && !blk_ready && close));
  assign take     = in_valid && in_ready && enable;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (take) begin
      square_sum   <= close ? '0 : sum_next;
      sample_count <= close ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (take && close) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && close) begin
      blk.sum   <= sum_next;
      blk.count <= 17'(cnt_next);
      blk.stamp <= time_ms;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count < CntW'(MAX_BLOCK)) else $error("count past block size");
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    take && close && !clear |=> sample_count == '0) else $error("count kept");
  a_no_take_off: assert property (@(posedge clk) disable iff (rst)
    !enable |-> !take) else $error("word counted while disabled");
endmodule

// ===== hw/rtl/alm_back.sv =====
// Back: divide, square root, smoothing, peak hold and display scaling.
`timescale 1ns / 1ps
module alm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  alm_pkg::cfg_t  cfg,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  alm_pkg::blk_t  blk,
  output logic           res_valid,
  input  logic           res_ready,
  output alm_pkg::res_t  res
);
  import alm_pkg::*;

  bst_t state, state_next;
  logic [SumW-1:0]  rem;     // dividend shifting out
  logic [SumW-1:0]  quo;
  logic [17:0]      drem;    // partial remainder
  logic [16:0]      dvs;
  logic [5:0]       step;
  logic [31:0]      root;
  logic [33:0]      srem;
  logic [TimeW-1:0] stamp;
  logic [15:0]      r, smoothed, peak;
  logic [TimeW-1:0] peak_stamp;
  logic [33:0]      mix;
  logic [22:0]      bars_prod;
  logic [22:0]      pct_prod;

  logic [17:0] dtry;
  logic [33:0] strial, sshift;
  logic [31:0] r_clamp;
  logic [16:0] fac_inv;
  logic [TimeW-1:0] dt;

  // Restoring divide: one quotient bit per cycle.
  assign dtry = {drem[16:0], rem[SumW-1]} - {1'b0, dvs};
  // Digit-by-digit square root: two radicand bits per cycle.
  assign sshift = {srem[31:0], quo[SumW-1 -: 2]};
  assign strial = sshift - {root, 2'b01};
  assign r_clamp = (root > 32'd32768) ? 32'd32768 : root;
  assign fac_inv = 17'd65536 - cfg.smoothing_factor;
  assign dt = stamp - peak_stamp;

  assign blk_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (blk_valid) state_next = S_DIV;
      S_DIV:    if (step == 6'(SumW - 1)) state_next = S_SQRT;
      S_SQRT:   if (step == 6'(SumW / 2 - 1)) state_next = S_SMOOTH;
      S_SMOOTH: state_next = S_SCALE;
      S_SCALE:  state_next = S_OUT;
      S_OUT:    if (!res_valid || res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rem <= blk.sum; dvs <= blk.count; drem <= '0; quo <= '0;
        step <= '0; stamp <= blk.stamp;
      end
      S_DIV: begin
        rem <= {rem[SumW-2:0], 1'b0};
        if (!dtry[17]) begin
          drem <= dtry; quo <= {quo[SumW-2:0], 1'b1};
        end else begin
          drem <= {drem[16:0], rem[SumW-1]}; quo <= {quo[SumW-2:0], 1'b0};
        end
        step <= (step == 6'(SumW - 1)) ? '0 : step + 6'd1;
        root <= '0; srem <= '0;
      end
      S_SQRT: begin
        quo <= {quo[SumW-3:0], 2'b00};
        if (!strial[33]) begin
          srem <= strial; root <= {root[30:0], 1'b1};
        end else begin
          srem <= sshift; root <= {root[30:0], 1'b0};
        end
        step <= step + 6'd1;
      end
      S_SMOOTH: begin
        r <= r_clamp[15:0];
        mix <= cfg.smoothing_factor * smoothed + fac_inv * r_clamp[16:0];
      end
      default: ;
    endcase
  end

  // Meter state and result word.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      smoothed <= '0; peak <= '0; peak_stamp <= '0;
    end else if (state == S_SCALE) begin
      smoothed <= ({1'b0, r} > {1'b0, smoothed}) ? r : mix[31:16];
      if (r > peak) begin
        peak <= r; peak_stamp <= stamp;
      end else if (dt > cfg.hold_time_ms) begin
        peak <= r;
      end
    end
  end

  assign bars_prod = smoothed * cfg.bar_count;
  assign pct_prod  = smoothed * 7'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!res_valid || res_ready)) begin
      res.rms_level      <= r;
      res.smoothed_level <= smoothed;
      res.peak_level     <= peak;
      res.clipping       <= r >= cfg.clip_threshold;
      res.level_bars     <= (bars_prod[22:15] > {1'b0, cfg.bar_count}) ?
                            cfg.bar_count : bars_prod[21:15];
      res.level_percent  <= (pct_prod[22:15] > 8'd100) ? 7'd100 : pct_prod[21:15];
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !blk_ready) else $error("queue taken while busy");
  a_lvl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.rms_level <= 16'd32768) else $error("rms over scale");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
endmodule

// ===== hw/rtl/audio_level_meter_core.sv =====
// Top level: audio RMS level meter with smoothing and peak hold.
//
//  channel  | dir | word
//  smp      | in  | sample, block_end, time_ms
//  res      | out | rms_level, smoothed_level, peak_level, clipping, bars, percent
//  cfg      | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// Samples are taken one per cycle unless stalled; each sample's square is added
// to the running sum as it is taken. While disabled each word is taken and dropped.
// A closed block holds the back end through the restoring divider, the square
// root unit, then the smooth, scale and output states; the result word is
// registered when the output state finds the result slot free.
// One closed block waits in the front register; a second closing word stalls
// until the back end takes the first, while other words keep flowing.
// Reset is synchronous; an enable rising edge clears the accumulator and the
// smoothed and peak levels and holds off input for that one clear cycle.
`timescale 1ns / 1ps
module audio_level_meter_core #(
  parameter int MAX_BLOCK = alm_pkg::MaxBlockDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [alm_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [alm_pkg::CfgDataW-1:0]  cfg_data,
  alm_in_if.sink                        smp,
  alm_out_if.source                     res
);
  import alm_pkg::*;

  logic  enable, clear, blk_valid, blk_ready;
  cfg_t  cfg;
  blk_t  blk;
  res_t  rw;

  // Configuration registers; a 0-to-1 enable write pulses clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0; clear <= 1'b0;
      cfg.smoothing_factor <= 17'd45875;
      cfg.hold_time_ms     <= 32'd1000;
      cfg.clip_threshold   <= 16'd32440;
      cfg.bar_count        <= 7'd16;
    end else begin
      clear <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          RegEnable: begin
            clear  <= cfg_data[0] && !enable;
            enable <= cfg_data[0];
          end
          RegSmoothing: cfg.smoothing_factor <= (cfg_data[16:0] > 17'd65536) ?
                                                17'd65536 : cfg_data[16:0];
          RegHoldTime:  cfg.hold_time_ms   <= cfg_data;
          RegClipThr:   cfg.clip_threshold <= cfg_data[15:0];
          RegMaxBars:   cfg.bar_count      <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  alm_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk, .rst, .clear, .enable(enable),
    .in_valid(smp.valid), .in_ready(smp.ready), .sample(smp.sample),
    .block_end(smp.block_end), .time_ms(smp.time_ms),
    .blk_valid, .blk_ready, .blk
  );

  alm_back u_back (
    .clk, .rst, .clear, .cfg, .blk_valid, .blk_ready, .blk,
    .res_valid(res.valid), .res_ready(res.ready), .res(rw)
  );

  assign res.rms_level      = rw.rms_level;
  assign res.smoothed_level = rw.smoothed_level;
  assign res.peak_level     = rw.peak_level;
  assign res.clipping       = rw.clipping;
  assign res.level_bars     = rw.level_bars;
  assign res.level_percent  = rw.level_percent;

  a_clr: assert property (@(posedge clk) disable iff (rst)
    clear |-> !$past(enable)) else $error("clear misfire");
  a_fac: assert property (@(posedge clk) disable iff (rst)
    cfg.smoothing_factor <= 17'd65536) else $error("factor over one");
  a_clr_rise: assert property (@(posedge clk) disable iff (rst)
    clear |-> enable) else $error("clear without enable");
endmodule
